[src/skc_pkg.sv]
// Shared widths, command codes and bus types for the styled key cache.
`timescale 1ns / 1ps
package skc_pkg;

  localparam int KEY_W   = 16;
  localparam int WIDTH_W = 32;
  localparam int STYLE_W = 2;
  localparam int SLOT_W  = 6;
  localparam int WOUT_W  = 31;

  localparam int DEF_STYLE_COUNT = 4;
  localparam int DEF_ENTRY_COUNT = 64;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // item travelling along the cell row
  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [STYLE_W-1:0] style;
    logic [SLOT_W-1:0]  slot;
    logic               matched;
    logic [WOUT_W-1:0]  wout;
  } tok_t;

  // column write broadcast to every cell
  typedef struct packed {
    logic                      en;
    logic [STYLE_W-1:0]        style;
    logic [KEY_W-1:0]          key;
    logic signed [WIDTH_W-1:0] width;
  } wr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] found_slot;
    logic              started_new;
    logic              closed_previous;
    logic [WOUT_W-1:0] width_out;
  } res_t;

endpackage

[src/skc_in_if.sv]
// Input item channel of the styled key cache.
`timescale 1ns / 1ps
interface skc_in_if;
  import skc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [KEY_W-1:0]          key;
  logic signed [WIDTH_W-1:0] width;
  logic [STYLE_W-1:0]        style;
  logic [SLOT_W-1:0]         slot;

  modport source (output valid, command, key, width, style, slot, input ready);
  modport sink   (input valid, command, key, width, style, slot, output ready);
endinterface

[src/skc_out_if.sv]
// Result item channel of the styled key cache.
`timescale 1ns / 1ps
interface skc_out_if;
  import skc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] found_slot;
  logic              started_new;
  logic              closed_previous;
  logic [WOUT_W-1:0] width_out;

  modport source (output valid, hit, found_slot, started_new, closed_previous, width_out,
                  input ready);
  modport sink   (input valid, hit, found_slot, started_new, closed_previous, width_out,
                  output ready);
endinterface

[src/styled_key_cache_with_flush.sv]
// Top level of the styled key cache: cell row, fill control and result register.
`timescale 1ns / 1ps
// Lookup/read cache of STYLE_COUNT rows by ENTRY_COUNT columns, built as a row of
// ENTRY_COUNT column cells. Each item enters the first cell and moves one cell per
// clock, comparing against (or reading) that column on the way; the result is then
// registered in the output register, or in a holding register while that is full.
// in_ch.ready rises again once the result is in the output register, so a new item
// is taken only after the last one is through. A miss writes the new column as the
// item leaves the row. A flush only rewinds the fill count: columns at or past the
// count read as zero, so there is no clearing pass after reset or flush. The user
// must write heading_style through cfg_we/cfg_wdata only while no item is in
// flight; the block itself does not enforce this.
module styled_key_cache_with_flush #(
  parameter int STYLE_COUNT = skc_pkg::DEF_STYLE_COUNT,
  parameter int ENTRY_COUNT = skc_pkg::DEF_ENTRY_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  skc_in_if.sink                       in_ch,
  skc_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [skc_pkg::STYLE_W-1:0]  cfg_wdata
);
  import skc_pkg::*;

  localparam int CW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic               busy_r;
  logic               first_r;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [STYLE_W-1:0] heading_r;
  logic               out_valid_r, hold_valid_r;
  res_t               out_r, hold_r, res;

  tok_t          tok_w   [ENTRY_COUNT+1];
  logic [CW-1:0] found_w [ENTRY_COUNT+1];
  tok_t          ex;
  logic [CW-1:0] ex_found;

  logic          acc, lookup_ok, miss_ins, do_flush, out_free;
  wr_t           wr;
  logic [CW-1:0] wr_col;

  logic signed [WIDTH_W-1:0] in_width_hold_r;

  assign in_ch.ready = !busy_r;
  assign acc         = in_ch.valid && !busy_r;

  always_comb begin
    tok_w[0].valid   = acc;
    tok_w[0].cmd     = in_ch.command;
    tok_w[0].key     = in_ch.key;
    tok_w[0].style   = in_ch.style;
    tok_w[0].slot    = in_ch.slot;
    tok_w[0].matched = 1'b0;
    tok_w[0].wout    = '0;
    found_w[0]       = '0;
  end

  for (genvar c = 0; c < ENTRY_COUNT; c++) begin : g_cell
    skc_cell #(
      .STYLE_COUNT(STYLE_COUNT),
      .ENTRY_COUNT(ENTRY_COUNT),
      .COL        (c),
      .CW         (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok_w[c]),
      .found_i (found_w[c]),
      .fill_i  (fill_r),
      .wr_i    (wr),
      .wr_col_i(wr_col),
      .tok_o   (tok_w[c+1]),
      .found_o (found_w[c+1])
    );
  end

  assign ex       = tok_w[ENTRY_COUNT];
  assign ex_found = found_w[ENTRY_COUNT];

  assign lookup_ok = (ex.cmd == CMD_LOOKUP) && (ex.style != heading_r)
                     && (int'(ex.style) < STYLE_COUNT);
  assign miss_ins  = ex.valid && lookup_ok && !ex.matched;
  assign do_flush  = miss_ins && ((fill_r == '0) || (fill_r >= CW'(ENTRY_COUNT - 1)));
  assign wr_col    = do_flush ? '0 : fill_r;
  assign fill_nxt  = wr_col + CW'(1);

  always_comb begin
    wr.en    = miss_ins;
    wr.style = ex.style;
    wr.key   = ex.key;
    wr.width = in_width_hold_r;
  end

  // width is not carried along the row; it stays put while the item is in flight
  always_ff @(posedge clk) begin
    if (acc) begin
      in_width_hold_r <= in_ch.width;
    end
  end

  always_comb begin
    res.hit             = lookup_ok && ex.matched;
    res.found_slot      = (lookup_ok && ex.matched) ? SLOT_W'(ex_found) : '0;
    res.started_new     = do_flush;
    res.closed_previous = do_flush && !first_r;
    res.width_out       = (ex.cmd == CMD_READ) ? ex.wout : '0;
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      first_r      <= 1'b1;
      fill_r       <= '0;
      heading_r    <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        heading_r <= cfg_wdata;
      end
      if (miss_ins) begin
        fill_r <= fill_nxt;
        if (do_flush) begin
          first_r <= 1'b0;
        end
      end
      if (acc) begin
        busy_r <= 1'b1;
      end
      if (ex.valid) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          hold_valid_r <= 1'b1;
        end
      end else if (hold_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex.valid) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        hold_r <= res;
      end
    end else if (hold_valid_r && out_free) begin
      out_r <= hold_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = out_r.hit;
  assign out_ch.found_slot      = out_r.found_slot;
  assign out_ch.started_new     = out_r.started_new;
  assign out_ch.closed_previous = out_r.closed_previous;
  assign out_ch.width_out       = out_r.width_out;

`ifndef SYNTH
  a_exit_busy : assert property (@(posedge clk) disable iff (!rst_n)
    ex.valid |-> busy_r)
    else $error("item left the cell row with no item in flight");

  a_hold_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("holding register full while output register empty");

  a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(ENTRY_COUNT - 1))
    else $error("fill count past last usable column");

  a_flush_fill : assert property (@(posedge clk) disable iff (!rst_n)
    do_flush |=> fill_r == CW'(1))
    else $error("flush did not restart the fill count");
`endif

endmodule

[src/skc_cell.sv]
// One column of the cache: keys and widths of every style, plus one stage of the item row.
`timescale 1ns / 1ps
module skc_cell #(
  parameter int STYLE_COUNT = skc_pkg::DEF_STYLE_COUNT,
  parameter int ENTRY_COUNT = skc_pkg::DEF_ENTRY_COUNT,
  parameter int COL         = 0,
  parameter int CW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  skc_pkg::tok_t   tok_i,
  input  logic [CW-1:0]   found_i,
  input  logic [CW-1:0]   fill_i,
  input  skc_pkg::wr_t    wr_i,
  input  logic [CW-1:0]   wr_col_i,
  output skc_pkg::tok_t   tok_o,
  output logic [CW-1:0]   found_o
);
  import skc_pkg::*;

  localparam int SW = (STYLE_COUNT > 1) ? $clog2(STYLE_COUNT) : 1;

  logic [KEY_W-1:0]          key_r   [STYLE_COUNT];
  logic signed [WIDTH_W-1:0] width_r [STYLE_COUNT];

  tok_t          tok_r, tok_nxt;
  logic [CW-1:0] found_r, found_nxt;
  logic [SW-1:0] sidx;
  logic          style_ok, col_used, slot_hit;
  logic signed [WIDTH_W-1:0] w_sel;

  assign sidx     = SW'(tok_i.style);
  assign style_ok = int'(tok_i.style) < STYLE_COUNT;
  assign col_used = CW'(COL) < fill_i;
  assign slot_hit = (COL < (2 ** SLOT_W)) && (tok_i.slot == SLOT_W'(COL));
  assign w_sel    = width_r[sidx];

  always_comb begin
    tok_nxt   = tok_i;
    found_nxt = found_i;
    if (tok_i.valid && style_ok && col_used) begin
      if (tok_i.cmd == CMD_LOOKUP) begin
        if (!tok_i.matched && key_r[sidx] == tok_i.key) begin
          tok_nxt.matched = 1'b1;
          found_nxt       = CW'(COL);
        end
      end else if (slot_hit) begin
        tok_nxt.wout = (w_sel > 0) ? w_sel[WOUT_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      found_r <= '0;
    end else begin
      tok_r   <= tok_nxt;
      found_r <= found_nxt;
    end
  end

  // a new column wipes every row and fills the one style
  always_ff @(posedge clk) begin
    if (wr_i.en && wr_col_i == CW'(COL)) begin
      for (int s = 0; s < STYLE_COUNT; s++) begin
        if (int'(wr_i.style) == s) begin
          key_r[s]   <= wr_i.key;
          width_r[s] <= wr_i.width;
        end else begin
          key_r[s]   <= '0;
          width_r[s] <= '0;
        end
      end
    end
  end

  assign tok_o   = tok_r;
  assign found_o = found_r;

endmodule
